// ===== design/psm_pkg.sv =====
// ----------------------------------------------------------------------------
// psm_pkg
// shared constants, codes and types of the primorial sieve marker
// ----------------------------------------------------------------------------
package psm_pkg;

    // sieve geometry
    localparam int SIEVE_SIZE  = 65536;
    localparam int WORD_BITS   = 32;
    localparam int WORD_SHIFT  = 5;
    localparam int SIEVE_WORDS = (SIEVE_SIZE + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W      = (SIEVE_WORDS > 1) ? $clog2(SIEVE_WORDS) : 1;

    // field widths
    localparam int FUNC_W    = 2;
    localparam int WADDR_W   = 11;
    localparam int DATA_W    = 32;
    localparam int OFFSET_W  = 16;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int POS_W     = DATA_W + 1;
    localparam int DIV_CNT_W = $clog2(PROD_W + 1);

    // request queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // function codes on the input port
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SIEVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_SIEVE,
        OP_READ,
        OP_NONE
    } t_op;

    // classified request handed from front to back
    typedef struct packed {
        t_op                op;
        logic               p_zero;
        logic               addr_ok;
        logic [ADDR_W-1:0]  addr;
        logic [DATA_W-1:0]  prime;
        logic [DATA_W-1:0]  diff;
        logic [DATA_W-1:0]  inverse;
    } t_cmd;

    typedef enum logic [3:0] {
        BS_INIT,
        BS_IDLE,
        BS_CLR,
        BS_MUL,
        BS_DVS,
        BS_DVW,
        BS_RD,
        BS_WR,
        BS_RDW,
        BS_FIN
    } t_bstate;

endpackage

// ===== design/psm_ram.sv =====
// ----------------------------------------------------------------------------
// psm_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module psm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/psm_mod_unit.sv =====
// ----------------------------------------------------------------------------
// psm_mod_unit
// restoring remainder of a 64-bit product by a 32-bit prime, one bit a cycle
// ----------------------------------------------------------------------------
module psm_mod_unit import psm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [PROD_W-1:0]  i_dividend,
    input  logic [DATA_W-1:0]  i_divisor,
    output logic               o_done,
    output logic [DATA_W-1:0]  o_rem
);

    logic                  r_run;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [PROD_W-1:0]     r_dvd;
    logic [DATA_W-1:0]     r_div;
    logic [DATA_W-1:0]     r_rem;

    logic [DATA_W:0]       trial;
    logic [DATA_W:0]       diff;
    logic                  ge;

    // partial remainder stays below the divisor, so one shift and subtract
    always_comb begin
        trial = {r_rem, r_dvd[PROD_W-1]};
        diff  = trial - {1'b0, r_div};
        ge    = (trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= DIV_CNT_W'(PROD_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_run) begin
            r_dvd <= {r_dvd[PROD_W-2:0], 1'b0};
            r_rem <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== design/psm_back.sv =====
// ----------------------------------------------------------------------------
// psm_back
// executes classified requests on the sieve memory and holds the result
// ----------------------------------------------------------------------------
module psm_back import psm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_head_v,
    input  t_cmd               i_head,
    output logic               o_q_pop,
    output logic               o_init,
    input  logic               i_pop,
    output logic               o_out_v,
    output logic [DATA_W-1:0]  o_read_data,
    output logic               o_done_res
);

    localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(SIEVE_WORDS - 1);
    localparam logic [POS_W-1:0]  POS_END   = POS_W'(SIEVE_SIZE);

    t_bstate             r_state, n_state;
    t_cmd                r_cmd, n_cmd;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [ADDR_W-1:0]   r_cnt, n_cnt;
    logic [DATA_W-1:0]   r_res_data, n_res_data;
    logic                r_res_done, n_res_done;
    logic                r_out_v, n_out_v;
    logic [DATA_W-1:0]   r_out_data, n_out_data;
    logic                r_out_done, n_out_done;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;
    logic                div_start;
    logic                div_done;
    logic [DATA_W-1:0]   div_rem;
    logic [ADDR_W-1:0]   pos_word;
    logic [DATA_W-1:0]   pos_mask;

    assign pos_word = r_pos[WORD_SHIFT +: ADDR_W];
    assign pos_mask = DATA_W'(1) << r_pos[WORD_SHIFT-1:0];

    psm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SIEVE_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    psm_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_cmd.prime),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_INIT;
            r_cnt   <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_prod     <= n_prod;
        r_pos      <= n_pos;
        r_res_data <= n_res_data;
        r_res_done <= n_res_done;
        r_out_data <= n_out_data;
        r_out_done <= n_out_done;
    end

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_prod     = r_prod;
        n_pos      = r_pos;
        n_cnt      = r_cnt;
        n_res_data = r_res_data;
        n_res_done = r_res_done;
        n_out_v    = r_out_v;
        n_out_data = r_out_data;
        n_out_done = r_out_done;
        ram_we     = 1'b0;
        ram_waddr  = r_cnt;
        ram_wdata  = '0;
        ram_raddr  = i_head.addr;
        o_q_pop    = 1'b0;
        div_start  = 1'b0;

        if (i_pop && r_out_v) begin
            n_out_v = 1'b0;
        end

        unique case (r_state)
            BS_INIT: begin
                ram_we = 1'b1;
                if (r_cnt == LAST_WORD) begin
                    n_cnt   = '0;
                    n_state = BS_IDLE;
                end else begin
                    n_cnt = r_cnt + ADDR_W'(1);
                end
            end
            BS_IDLE: begin
                if (i_head_v) begin
                    o_q_pop    = 1'b1;
                    n_cmd      = i_head;
                    n_res_data = '0;
                    n_res_done = 1'b1;
                    unique case (i_head.op)
                        OP_CLEAR: begin
                            n_cnt   = '0;
                            n_state = BS_CLR;
                        end
                        OP_SIEVE: begin
                            n_state = i_head.p_zero ? BS_FIN : BS_MUL;
                        end
                        OP_READ: begin
                            n_state = i_head.addr_ok ? BS_RDW : BS_FIN;
                        end
                        OP_NONE: begin
                            n_res_done = 1'b0;
                            n_state    = BS_FIN;
                        end
                        default: begin
                            n_state = BS_FIN;
                        end
                    endcase
                end
            end
            BS_CLR: begin
                ram_we = 1'b1;
                if (r_cnt == LAST_WORD) begin
                    n_cnt   = '0;
                    n_state = BS_FIN;
                end else begin
                    n_cnt = r_cnt + ADDR_W'(1);
                end
            end
            BS_MUL: begin
                n_prod  = PROD_W'(r_cmd.diff) * PROD_W'(r_cmd.inverse);
                n_state = BS_DVS;
            end
            BS_DVS: begin
                div_start = 1'b1;
                n_state   = BS_DVW;
            end
            BS_DVW: begin
                if (div_done) begin
                    n_pos   = {1'b0, div_rem};
                    n_state = BS_RD;
                end
            end
            BS_RD: begin
                ram_raddr = pos_word;
                if (r_pos < POS_END) begin
                    n_state = BS_WR;
                end else begin
                    n_state = BS_FIN;
                end
            end
            BS_WR: begin
                ram_we    = 1'b1;
                ram_waddr = pos_word;
                ram_wdata = ram_rdata | pos_mask;
                n_pos     = r_pos + {1'b0, r_cmd.prime};
                n_state   = BS_RD;
            end
            BS_RDW: begin
                n_res_data = ram_rdata;
                n_state    = BS_FIN;
            end
            BS_FIN: begin
                if (!r_out_v || i_pop) begin
                    n_out_v    = 1'b1;
                    n_out_data = r_res_data;
                    n_out_done = r_res_done;
                    n_state    = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    assign o_init      = (r_state == BS_INIT);
    assign o_out_v     = r_out_v;
    assign o_read_data = r_out_data;
    assign o_done_res  = r_out_done;

endmodule

// ===== design/psm_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// psm_cmd_fifo
// short register queue of classified requests between front and back
// ----------------------------------------------------------------------------
module psm_cmd_fifo import psm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_cmd  i_wdata,
    output logic  o_full,
    input  logic  i_rd,
    output t_cmd  o_rdata,
    output logic  o_empty
);

    localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);

    t_cmd               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wptr;
    logic [QPTR_W-1:0]  r_rptr;
    logic [QCNT_W-1:0]  r_cnt;
    logic               do_wr;
    logic               do_rd;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_wr) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + QPTR_W'(1);
            end
            if (do_rd) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + QPTR_W'(1);
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

// ===== design/psm_front.sv =====
// ----------------------------------------------------------------------------
// psm_front
// accepts requests, forms the reduced remainder and classifies each request
// ----------------------------------------------------------------------------
module psm_front import psm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic                i_hold,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [DATA_W-1:0]   i_prime,
    input  logic [DATA_W-1:0]   i_inverse,
    input  logic [DATA_W-1:0]   i_base_remainder,
    input  logic [OFFSET_W-1:0] i_offset,
    input  logic [WADDR_W-1:0]  i_word_addr,
    input  logic                i_q_full,
    output logic                o_q_wr,
    output t_cmd                o_cmd
);

    // stage one: raw request plus remainder sum
    logic                r_s1_v;
    logic [FUNC_W-1:0]   r_s1_func;
    logic [DATA_W-1:0]   r_s1_prime;
    logic [DATA_W-1:0]   r_s1_inv;
    logic [DATA_W-1:0]   r_s1_sum;
    logic [WADDR_W-1:0]  r_s1_addr;
    // stage two: classified request
    logic                r_s2_v;
    t_cmd                r_s2_cmd;

    logic                s2_ready;
    logic                s1_ready;
    logic                s1_move;
    logic                accept;
    t_cmd                cls;
    logic [DATA_W-1:0]   addr_ext;

    assign s2_ready = !r_s2_v || !i_q_full;
    assign s1_ready = !r_s1_v || s2_ready;
    assign s1_move  = r_s1_v && s2_ready;
    assign o_full   = !s1_ready || i_hold;
    assign accept   = i_push && !o_full;
    assign o_q_wr   = r_s2_v && !i_q_full;
    assign o_cmd    = r_s2_cmd;
    assign addr_ext = DATA_W'(r_s1_addr);

    always_comb begin
        cls.prime   = r_s1_prime;
        cls.inverse = r_s1_inv;
        cls.p_zero  = (r_s1_prime == '0);
        cls.addr_ok = (addr_ext < DATA_W'(SIEVE_WORDS));
        cls.addr    = addr_ext[ADDR_W-1:0];
        // p - (sum - p) when the sum passed the prime, all modulo 2^32
        if (r_s1_prime < r_s1_sum) begin
            cls.diff = {r_s1_prime[DATA_W-2:0], 1'b0} - r_s1_sum;
        end else begin
            cls.diff = r_s1_prime - r_s1_sum;
        end
        unique case (r_s1_func)
            FUNC_CLEAR: cls.op = OP_CLEAR;
            FUNC_SIEVE: cls.op = OP_SIEVE;
            FUNC_READ:  cls.op = OP_READ;
            default:    cls.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_v <= 1'b1;
            end else if (s1_move) begin
                r_s1_v <= 1'b0;
            end
            if (s1_move) begin
                r_s2_v <= 1'b1;
            end else if (o_q_wr) begin
                r_s2_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_func  <= i_func;
            r_s1_prime <= i_prime;
            r_s1_inv   <= i_inverse;
            r_s1_sum   <= i_base_remainder + DATA_W'(i_offset);
            r_s1_addr  <= i_word_addr;
        end
        if (s1_move) begin
            r_s2_cmd <= cls;
        end
    end

endmodule

// ===== design/primorial_sieve_marker_core.sv =====
// ----------------------------------------------------------------------------
// primorial_sieve_marker_core
// sieve bit array of primorial multiples with clear, mark and word read
// ----------------------------------------------------------------------------
// The block keeps a 65536-bit sieve in a 2048 x 32 memory (bit k of word w
// is position 32*w + k; a set bit marks a composite). Requests enter through
// push/full and one result per request leaves through empty/pop, in order.
// A two-stage front forms base_remainder + offset, folds it once against
// the prime and works out prime - remainder, then parks the request in a
// two-entry queue; the back unit runs one request at a time. After reset
// the back sweeps the memory to zero, one word a cycle, and full stays
// high meanwhile. Per request the back steps through these states, from
// picking the request off the queue until the result register loads: a
// clear runs pick-up, the same one-word-a-cycle sweep and the load; a read
// runs pick-up, memory read and load; a sieve runs pick-up, the 32x32
// multiply, the divider start and the 64-step bit-serial remainder unit,
// then a read-modify-write per marked bit on the single memory port pair,
// and the load to finish; it marks nothing when the start lies past the
// array. The finish waits while an unread result still sits in the
// result register. A zero prime marks nothing, a read beyond the array
// returns zero, and an unused function code returns read_data 0 with
// done_res 0.
// ----------------------------------------------------------------------------
module primorial_sieve_marker_core import psm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request side
    input  logic                push,
    output logic                full,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [DATA_W-1:0]   i_prime,
    input  logic [DATA_W-1:0]   i_inverse,
    input  logic [DATA_W-1:0]   i_base_remainder,
    input  logic [OFFSET_W-1:0] i_offset,
    input  logic [WADDR_W-1:0]  i_word_addr,
    // result side
    output logic                empty,
    input  logic                pop,
    output logic [DATA_W-1:0]   o_read_data,
    output logic                o_done_res
);

    // front to queue
    logic  q_wr;
    t_cmd  q_wdata;
    logic  q_full;
    // queue to back
    logic  q_rd;
    t_cmd  q_head;
    logic  q_empty;
    // back status
    logic  init_busy;
    logic  out_v;

    // front: request intake and classification, held off during the
    // power-up clearing sweep
    psm_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_hold           (init_busy),
        .i_func           (i_func),
        .i_prime          (i_prime),
        .i_inverse        (i_inverse),
        .i_base_remainder (i_base_remainder),
        .i_offset         (i_offset),
        .i_word_addr      (i_word_addr),
        .i_q_full         (q_full),
        .o_q_wr           (q_wr),
        .o_cmd            (q_wdata)
    );

    // decoupling queue so intake keeps going while the back marks bits
    psm_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_rdata (q_head),
        .o_empty (q_empty)
    );

    // back: memory sweeps, multiply, remainder and marking loop, result reg
    psm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head_v    (!q_empty),
        .i_head      (q_head),
        .o_q_pop     (q_rd),
        .o_init      (init_busy),
        .i_pop       (pop),
        .o_out_v     (out_v),
        .o_read_data (o_read_data),
        .o_done_res  (o_done_res)
    );

    assign empty = !out_v;

endmodule
